[sv/cascaded_biquad_iir_filter_top_defines.svh]
// assertion macros shared by the cascaded biquad filter rtl
`ifndef CASCADED_BIQUAD_IIR_FILTER_TOP_DEFINES_SVH
`define CASCADED_BIQUAD_IIR_FILTER_TOP_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define CBQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define CBQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/cbq_pkg.sv]
// types, constants and helper functions for the cascaded biquad filter
package cbq_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int COEF_WIDTH   = 32;
    localparam int NUM_SECTIONS = 2;

    localparam int HIST_W    = 40;
    localparam int STATE_FRAC = 32;
    localparam int COEF_FRAC = COEF_WIDTH - 4;
    localparam int IN_SHIFT  = STATE_FRAC - (SAMPLE_WIDTH - 1);
    localparam int XW        = SAMPLE_WIDTH + IN_SHIFT;

    // multiplier operand split of a history value
    localparam int SPLIT   = 20;
    localparam int HALF_W  = SPLIT + 1;
    localparam int MUL_W   = COEF_WIDTH + HALF_W;
    localparam int PART_W  = MUL_W + SPLIT;
    localparam int PROD_W  = PART_W - COEF_FRAC;
    localparam int ACC_W   = PROD_W + 3;

    localparam int SEC_W   = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
    localparam int ISSUE_W = 4;
    localparam int CNT_W   = 3;
    localparam int PASS_W  = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_WIDTH;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_B0        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B1        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B2        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A1        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A2        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FORM_SELECT    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CASCADE_ENABLE = 3'd6;

    localparam logic FORM_DF1  = 1'b0;
    localparam logic FORM_TDF2 = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_in;
        logic                           end_of_block;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_out;
        logic                           end_of_block_out;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ISSUE,
        S_DRAIN1,
        S_DRAIN2,
        S_FIN,
        S_SAVE,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        C_B0,
        C_B1,
        C_B2,
        C_A1,
        C_A2
    } coef_sel_t;

    typedef enum logic [2:0] {
        O_ZERO,
        O_X,
        O_W0,
        O_W1,
        O_W2,
        O_W3,
        O_V
    } opd_sel_t;

    typedef struct packed {
        coef_sel_t coef_sel;
        opd_sel_t  opd_sel;
        logic      neg;
    } term_t;

    // control of one half-multiply issued to the mac
    typedef struct packed {
        logic valid;
        logic hi;
        logic neg;
        logic load;
    } mac_op_t;

    typedef struct packed {
        logic busy;
    } mac_stat_t;

    function automatic term_t term_of(logic form, logic [PASS_W-1:0] pass,
                                      logic [CNT_W-1:0] idx);
        term_t t;
        t = '{coef_sel: C_B0, opd_sel: O_X, neg: 1'b0};
        if (form == FORM_DF1) begin
            unique case (idx)
                3'd0:    t = '{coef_sel: C_B0, opd_sel: O_X,  neg: 1'b0};
                3'd1:    t = '{coef_sel: C_B1, opd_sel: O_W0, neg: 1'b0};
                3'd2:    t = '{coef_sel: C_B2, opd_sel: O_W1, neg: 1'b0};
                3'd3:    t = '{coef_sel: C_A1, opd_sel: O_W2, neg: 1'b1};
                default: t = '{coef_sel: C_A2, opd_sel: O_W3, neg: 1'b1};
            endcase
        end else begin
            unique case (pass)
                2'd0:    t = '{coef_sel: C_B0, opd_sel: O_X, neg: 1'b0};
                2'd1:    t = (idx == 3'd0) ? term_t'{coef_sel: C_B1, opd_sel: O_X, neg: 1'b0}
                                           : term_t'{coef_sel: C_A1, opd_sel: O_V, neg: 1'b1};
                default: t = (idx == 3'd0) ? term_t'{coef_sel: C_B2, opd_sel: O_X, neg: 1'b0}
                                           : term_t'{coef_sel: C_A2, opd_sel: O_V, neg: 1'b1};
            endcase
        end
        return t;
    endfunction

    function automatic logic [CNT_W-1:0] term_count(logic form, logic [PASS_W-1:0] pass);
        logic [CNT_W-1:0] n;
        if (form == FORM_DF1)
            n = 3'd5;
        else if (pass == 2'd0)
            n = 3'd1;
        else
            n = 3'd2;
        return n;
    endfunction

    function automatic opd_sel_t base_of(logic form, logic [PASS_W-1:0] pass);
        opd_sel_t b;
        if (form == FORM_DF1)
            b = O_ZERO;
        else if (pass == 2'd0)
            b = O_W0;
        else if (pass == 2'd1)
            b = O_W1;
        else
            b = O_ZERO;
        return b;
    endfunction

    function automatic logic last_pass(logic form, logic [PASS_W-1:0] pass);
        return (form == FORM_DF1) || (pass == 2'd2);
    endfunction

    function automatic logic signed [HIST_W-1:0] sat_hist(logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        logic signed [HIST_W-1:0] r;
        hi = ACC_W'({1'b0, {(HIST_W-1){1'b1}}});
        lo = -hi - ACC_W'(1);
        if (v > hi)
            r = {1'b0, {(HIST_W-1){1'b1}}};
        else if (v < lo)
            r = {1'b1, {(HIST_W-1){1'b0}}};
        else
            r = v[HIST_W-1:0];
        return r;
    endfunction

    // round half up from q8.32 to the sample grid, then clamp to [-1, 1)
    function automatic logic signed [SAMPLE_WIDTH-1:0] to_sample(logic signed [HIST_W-1:0] v);
        logic signed [HIST_W:0] r;
        logic signed [HIST_W:0] hi;
        logic signed [HIST_W:0] lo;
        logic signed [SAMPLE_WIDTH-1:0] s;
        r  = ($signed({v[HIST_W-1], v}) + ((HIST_W+1)'(1) <<< (IN_SHIFT - 1))) >>> IN_SHIFT;
        hi = (HIST_W+1)'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
        lo = -hi - (HIST_W+1)'(1);
        if (r > hi)
            s = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        else if (r < lo)
            s = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        else
            s = r[SAMPLE_WIDTH-1:0];
        return s;
    endfunction

    function automatic logic signed [HIST_W-1:0] to_hist(logic signed [SAMPLE_WIDTH-1:0] s);
        logic [XW-1:0] t;
        t = {s, {IN_SHIFT{1'b0}}};
        return {{(HIST_W-XW){t[XW-1]}}, t};
    endfunction

endpackage

[sv/cbq_mac.sv]
// shared multiply-accumulate unit: one half-width product per cycle, exact floor per term
module cbq_mac (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  cbq_pkg::mac_op_t                      op,
    input  logic signed [cbq_pkg::COEF_WIDTH-1:0] coef,
    input  logic signed [cbq_pkg::HIST_W-1:0]     opd,
    input  logic signed [cbq_pkg::HIST_W-1:0]     base,
    output logic signed [cbq_pkg::ACC_W-1:0]      acc,
    output cbq_pkg::mac_stat_t                    stat
);

    logic signed [cbq_pkg::HALF_W-1:0] half;
    logic signed [cbq_pkg::MUL_W-1:0]  mul_reg;
    logic signed [cbq_pkg::PART_W-1:0] part_reg;
    logic signed [cbq_pkg::ACC_W-1:0]  acc_reg;
    logic signed [cbq_pkg::ACC_W-1:0]  prod;
    logic                              v1_reg;
    logic                              hi1_reg;
    logic                              neg1_reg;
    logic                              v2_reg;
    logic                              neg2_reg;

    // high half signed, low half as a positive offset
    assign half = op.hi ? {opd[cbq_pkg::HIST_W-1], opd[cbq_pkg::HIST_W-1:cbq_pkg::SPLIT]}
                        : {1'b0, opd[cbq_pkg::SPLIT-1:0]};

    // floor of the exact product by the coefficient scale
    assign prod = {{(cbq_pkg::ACC_W-cbq_pkg::PROD_W){part_reg[cbq_pkg::PART_W-1]}},
                   part_reg[cbq_pkg::PART_W-1:cbq_pkg::COEF_FRAC]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            hi1_reg  <= 1'b0;
            neg1_reg <= 1'b0;
            v2_reg   <= 1'b0;
            neg2_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= op.valid;
            hi1_reg  <= op.hi;
            neg1_reg <= op.neg;
            v2_reg   <= v1_reg && !hi1_reg;
            neg2_reg <= neg1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.valid)
            mul_reg <= coef * half;
        if (v1_reg)
        begin
            if (hi1_reg)
                part_reg <= {mul_reg, {cbq_pkg::SPLIT{1'b0}}};
            else
                part_reg <= part_reg + {{cbq_pkg::SPLIT{mul_reg[cbq_pkg::MUL_W-1]}}, mul_reg};
        end
        if (op.valid && op.load)
            acc_reg <= {{(cbq_pkg::ACC_W-cbq_pkg::HIST_W){base[cbq_pkg::HIST_W-1]}}, base};
        else if (v2_reg)
            acc_reg <= neg2_reg ? (acc_reg - prod) : (acc_reg + prod);
    end

    assign acc       = acc_reg;
    assign stat.busy = v1_reg || v2_reg;

endmodule

[sv/cascaded_biquad_iir_filter_top.sv]
// cascaded biquad iir filter, direct form i or transposed direct form ii, on one shared mac
//
// One item is taken at a time; the input stalls until the result is in the output
// register. All multiplies run on a single 32x21 multiplier, two half-products per
// coefficient term, followed by a two-stage drain into the accumulator. Per section,
// direct form I loads the history, issues its five terms, then drains, finishes and saves;
// transposed form II computes three sums, each drained before the next because of the
// feedback on the section output. Each item passes through the idle and done states
// around one section with cascade off, or both with cascade on. History is cleared by
// reset; coefficients and modes reset to zero and may be written only while the block is idle.
`include "cascaded_biquad_iir_filter_top_defines.svh"

module cascaded_biquad_iir_filter_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [cbq_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cbq_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  cbq_pkg::in_item_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output cbq_pkg::out_item_t                   out_data
);

    // configuration
    logic signed [cbq_pkg::COEF_WIDTH-1:0] coef_b0_reg;
    logic signed [cbq_pkg::COEF_WIDTH-1:0] coef_b1_reg;
    logic signed [cbq_pkg::COEF_WIDTH-1:0] coef_b2_reg;
    logic signed [cbq_pkg::COEF_WIDTH-1:0] coef_a1_reg;
    logic signed [cbq_pkg::COEF_WIDTH-1:0] coef_a2_reg;
    logic                                  form_reg;
    logic                                  cascade_enable_reg;

    // sequencer
    cbq_pkg::state_t                state_reg;
    cbq_pkg::state_t                state_next;
    logic [cbq_pkg::SEC_W-1:0]      sec_reg;
    logic [cbq_pkg::SEC_W-1:0]      sec_next;
    logic [cbq_pkg::PASS_W-1:0]     pass_reg;
    logic [cbq_pkg::PASS_W-1:0]     pass_next;
    logic [cbq_pkg::ISSUE_W-1:0]    issue_reg;
    logic [cbq_pkg::ISSUE_W-1:0]    issue_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;

    // datapath
    logic signed [cbq_pkg::HIST_W-1:0] hist_reg [cbq_pkg::NUM_SECTIONS][4];
    logic signed [cbq_pkg::HIST_W-1:0] w_reg [4];
    logic signed [cbq_pkg::HIST_W-1:0] x_reg;
    logic signed [cbq_pkg::HIST_W-1:0] v_reg;
    logic                              eob_reg;
    cbq_pkg::out_item_t                out_reg;

    logic                              accept;
    logic                              out_free;
    logic                              last_issue;
    logic                              more_sections;
    logic [cbq_pkg::CNT_W-1:0]         count;
    cbq_pkg::term_t                    term;
    cbq_pkg::mac_op_t                  mac_op;
    cbq_pkg::mac_stat_t                mac_stat;
    logic signed [cbq_pkg::COEF_WIDTH-1:0] coef_sel;
    logic signed [cbq_pkg::HIST_W-1:0] opd_sel;
    logic signed [cbq_pkg::HIST_W-1:0] base_sel;
    logic signed [cbq_pkg::ACC_W-1:0]  acc;
    logic signed [cbq_pkg::HIST_W-1:0] sat_v;

    function automatic logic signed [cbq_pkg::HIST_W-1:0] pick(
        cbq_pkg::opd_sel_t sel,
        logic signed [cbq_pkg::HIST_W-1:0] x,
        logic signed [cbq_pkg::HIST_W-1:0] w0,
        logic signed [cbq_pkg::HIST_W-1:0] w1,
        logic signed [cbq_pkg::HIST_W-1:0] w2,
        logic signed [cbq_pkg::HIST_W-1:0] w3,
        logic signed [cbq_pkg::HIST_W-1:0] v);
        logic signed [cbq_pkg::HIST_W-1:0] r;
        unique case (sel)
            cbq_pkg::O_X:  r = x;
            cbq_pkg::O_W0: r = w0;
            cbq_pkg::O_W1: r = w1;
            cbq_pkg::O_W2: r = w2;
            cbq_pkg::O_W3: r = w3;
            cbq_pkg::O_V:  r = v;
            default:       r = '0;
        endcase
        return r;
    endfunction

    assign accept        = in_valid && !in_stall;
    assign out_free      = !out_valid_reg || !out_stall;
    assign count         = cbq_pkg::term_count(form_reg, pass_reg);
    assign last_issue    = (issue_reg == {count - cbq_pkg::CNT_W'(1), 1'b1});
    assign more_sections = cascade_enable_reg
                           && (sec_reg != cbq_pkg::SEC_W'(cbq_pkg::NUM_SECTIONS - 1));
    assign term          = cbq_pkg::term_of(form_reg, pass_reg,
                                            issue_reg[cbq_pkg::ISSUE_W-1:1]);
    assign sat_v         = cbq_pkg::sat_hist(acc);

    always_comb
    begin
        unique case (term.coef_sel)
            cbq_pkg::C_B0: coef_sel = coef_b0_reg;
            cbq_pkg::C_B1: coef_sel = coef_b1_reg;
            cbq_pkg::C_B2: coef_sel = coef_b2_reg;
            cbq_pkg::C_A1: coef_sel = coef_a1_reg;
            cbq_pkg::C_A2: coef_sel = coef_a2_reg;
            default:       coef_sel = '0;
        endcase
    end

    assign opd_sel  = pick(term.opd_sel, x_reg, w_reg[0], w_reg[1], w_reg[2], w_reg[3],
                           v_reg);
    assign base_sel = pick(cbq_pkg::base_of(form_reg, pass_reg), x_reg, w_reg[0],
                           w_reg[1], w_reg[2], w_reg[3], v_reg);

    // next state
    always_comb
    begin
        state_next     = state_reg;
        sec_next       = sec_reg;
        pass_next      = pass_reg;
        issue_next     = issue_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            cbq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = cbq_pkg::S_LOAD;
                    sec_next   = '0;
                end
            end
            cbq_pkg::S_LOAD:
            begin
                state_next = cbq_pkg::S_ISSUE;
                pass_next  = '0;
                issue_next = '0;
            end
            cbq_pkg::S_ISSUE:
            begin
                issue_next = issue_reg + cbq_pkg::ISSUE_W'(1);
                if (last_issue)
                    state_next = cbq_pkg::S_DRAIN1;
            end
            cbq_pkg::S_DRAIN1: state_next = cbq_pkg::S_DRAIN2;
            cbq_pkg::S_DRAIN2: state_next = cbq_pkg::S_FIN;
            cbq_pkg::S_FIN:
            begin
                if (cbq_pkg::last_pass(form_reg, pass_reg))
                    state_next = cbq_pkg::S_SAVE;
                else
                begin
                    state_next = cbq_pkg::S_ISSUE;
                    pass_next  = pass_reg + cbq_pkg::PASS_W'(1);
                    issue_next = '0;
                end
            end
            cbq_pkg::S_SAVE:
            begin
                if (more_sections)
                begin
                    state_next = cbq_pkg::S_LOAD;
                    sec_next   = sec_reg + cbq_pkg::SEC_W'(1);
                end
                else
                    state_next = cbq_pkg::S_DONE;
            end
            cbq_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next     = cbq_pkg::S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = cbq_pkg::S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_stall     = (state_reg != cbq_pkg::S_IDLE);
        mac_op.valid = (state_reg == cbq_pkg::S_ISSUE);
        mac_op.hi    = !issue_reg[0];
        mac_op.neg   = term.neg;
        mac_op.load  = (issue_reg == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= cbq_pkg::S_IDLE;
            sec_reg            <= '0;
            pass_reg           <= '0;
            issue_reg          <= '0;
            out_valid_reg      <= 1'b0;
            coef_b0_reg        <= '0;
            coef_b1_reg        <= '0;
            coef_b2_reg        <= '0;
            coef_a1_reg        <= '0;
            coef_a2_reg        <= '0;
            form_reg           <= cbq_pkg::FORM_DF1;
            cascade_enable_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sec_reg       <= sec_next;
            pass_reg      <= pass_next;
            issue_reg     <= issue_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    cbq_pkg::REG_COEF_B0:        coef_b0_reg <= cfg_wdata;
                    cbq_pkg::REG_COEF_B1:        coef_b1_reg <= cfg_wdata;
                    cbq_pkg::REG_COEF_B2:        coef_b2_reg <= cfg_wdata;
                    cbq_pkg::REG_COEF_A1:        coef_a1_reg <= cfg_wdata;
                    cbq_pkg::REG_COEF_A2:        coef_a2_reg <= cfg_wdata;
                    cbq_pkg::REG_FORM_SELECT:    form_reg <= cfg_wdata[0];
                    cbq_pkg::REG_CASCADE_ENABLE: cascade_enable_reg <= cfg_wdata[0];
                    default:                     ;
                endcase
            end
        end
    end

    // section history, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < cbq_pkg::NUM_SECTIONS; s++)
            begin
                for (int k = 0; k < 4; k++)
                    hist_reg[s][k] <= '0;
            end
        end
        else if (state_reg == cbq_pkg::S_SAVE)
        begin
            for (int k = 0; k < 4; k++)
                hist_reg[sec_reg][k] <= w_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            cbq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    x_reg   <= cbq_pkg::to_hist(in_data.sample_in);
                    eob_reg <= in_data.end_of_block;
                end
            end
            cbq_pkg::S_LOAD:
            begin
                for (int k = 0; k < 4; k++)
                    w_reg[k] <= hist_reg[sec_reg][k];
            end
            cbq_pkg::S_FIN:
            begin
                if (form_reg == cbq_pkg::FORM_DF1)
                begin
                    v_reg    <= sat_v;
                    w_reg[0] <= x_reg;
                    w_reg[1] <= w_reg[0];
                    w_reg[2] <= sat_v;
                    w_reg[3] <= w_reg[2];
                end
                else
                begin
                    unique case (pass_reg)
                        2'd0:    v_reg <= sat_v;
                        2'd1:    w_reg[0] <= sat_v;
                        default: w_reg[1] <= sat_v;
                    endcase
                end
            end
            cbq_pkg::S_SAVE:
            begin
                // clamped output of this section is the next section's input
                if (more_sections)
                    x_reg <= cbq_pkg::to_hist(cbq_pkg::to_sample(v_reg));
            end
            cbq_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_reg.sample_out       <= cbq_pkg::to_sample(v_reg);
                    out_reg.end_of_block_out <= eob_reg;
                end
            end
            default: ;
        endcase
    end

    cbq_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mac_op),
        .coef  (coef_sel),
        .opd   (opd_sel),
        .base  (base_sel),
        .acc   (acc),
        .stat  (mac_stat)
    );

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `CBQ_ASSERT_SAME(a_fin_drained, state_reg == cbq_pkg::S_FIN, !mac_stat.busy, "sum read before mac drained")
    `CBQ_ASSERT_NEXT(a_accept_starts, accept, state_reg == cbq_pkg::S_LOAD, "accepted item did not start a section")
    `CBQ_ASSERT_SAME(a_sec_cascade, (state_reg != cbq_pkg::S_IDLE) && (sec_reg != '0), cascade_enable_reg, "second section ran with cascade off")
    `CBQ_ASSERT_NEXT(a_done_delivers, (state_reg == cbq_pkg::S_DONE) && out_free, out_valid_reg, "finished item not presented")

endmodule
